### sv/ssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, constants and the seven-segment table for the stopwatch.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int unsigned NUM_DIGITS_DEF = 4;
  localparam int unsigned NUM_DIGITS_MAX = 6;

  localparam int unsigned COUNT_W   = 14;
  localparam int unsigned LOCKOUT_W = 10;
  localparam int unsigned BCD_W     = 4;
  localparam int unsigned NUM_CELLS = 4;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned SEL_W     = 2;
  localparam int unsigned SEG_W     = 8;

  localparam logic [COUNT_W-1:0]   COUNT_LAST    = 14'd9999;
  localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 10'd100;
  localparam logic [BCD_W-1:0]     BCD_LAST      = 4'd9;
  localparam logic [POS_W-1:0]     DP_DIGIT      = 3'd2;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_BUTTON = 2'd1,
    CMD_SCAN   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // Control handed to each counter cell.
  typedef struct packed {
    logic clear;
    logic inc;
  } cell_ctrl_t;

  // Active-low segment code of one decimal digit, decimal point dark.
  function automatic logic [SEG_W-1:0] seg_code(input logic [BCD_W-1:0] d);
    logic [SEG_W-1:0] code;
    case (d)
      4'd0: code = 8'hc0;
      4'd1: code = 8'hf9;
      4'd2: code = 8'ha4;
      4'd3: code = 8'hb0;
      4'd4: code = 8'h99;
      4'd5: code = 8'h92;
      4'd6: code = 8'h82;
      4'd7: code = 8'hf8;
      4'd8: code = 8'h80;
      4'd9: code = 8'h90;
      default: code = 8'hc0;
    endcase
    return code;
  endfunction

endpackage

### sv/ssd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_in_if / ssd_out_if
// Valid/ready channels carrying the input and result words.
// ----------------------------------------------------------------------------
interface ssd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic       level;

  modport source (output valid, output cmd, output level, input ready);
  modport sink   (input valid, input cmd, input level, output ready);
endinterface

interface ssd_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] count;
  logic        running;
  logic        toggled;
  logic [1:0]  digit_select;
  logic [7:0]  segments;

  modport source (output valid, output count, output running, output toggled,
                  output digit_select, output segments, input ready);
  modport sink   (input valid, input count, input running, input toggled,
                  input digit_select, input segments, output ready);
endinterface

### sv/start_stop_stopwatch_display_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// start_stop_stopwatch_display_top
// Start/stop stopwatch with a multiplexed seven-segment digit scan.
// ----------------------------------------------------------------------------
// Every accepted word (tick, button sample or scan step) yields exactly one
// result word, held in an output register from the cycle after acceptance.
// A new word is taken in every cycle while that register is empty or being
// read, so the block sustains one word per clock; it stalls only while the
// downstream side holds ready low with a result waiting. The centisecond
// count is kept both as a binary value and in a row of four decimal cells
// linked by their carries, which wrap together at 10000 and feed the
// segment decoder directly.
module start_stop_stopwatch_display_top #(
  parameter int unsigned NumDigits = ssd_pkg::NUM_DIGITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ssd_pkg::LOCKOUT_W-1:0]   cfg_data_i,
  ssd_in_if.sink                          in_i,
  ssd_out_if.source                       out_o
);

  localparam int unsigned ScanW = (NumDigits > 1) ? $clog2(NumDigits) : 1;
  localparam logic [ScanW-1:0] ScanLast = ScanW'(NumDigits - 1);

  logic                            accept;
  logic [ssd_pkg::LOCKOUT_W-1:0]   lockout_ticks_q;
  logic [ssd_pkg::COUNT_W-1:0]     elapsed_q, elapsed_d;
  logic                            run_q, run_d;
  logic                            prev_q, prev_d;
  logic [ssd_pkg::LOCKOUT_W-1:0]   lockout_q, lockout_d;
  logic [ScanW-1:0]                scan_q, scan_d;
  logic                            toggled;
  logic                            clear_cnt, inc_cnt;

  ssd_pkg::cell_ctrl_t             cell_ctrl [ssd_pkg::NUM_CELLS];
  logic [ssd_pkg::NUM_CELLS-1:0]   carry;
  logic [ssd_pkg::BCD_W-1:0]       digit_d [ssd_pkg::NUM_CELLS];

  logic [ssd_pkg::POS_W-1:0]       pos;
  logic [ssd_pkg::BCD_W-1:0]       shown;
  logic [ssd_pkg::SEG_W-1:0]       seg;

  logic                            out_valid_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_ticks_q <= ssd_pkg::LOCKOUT_RESET;
    end else if (cfg_we_i) begin
      lockout_ticks_q <= cfg_data_i;
    end
  end

  always_comb begin
    elapsed_d = elapsed_q;
    run_d     = run_q;
    prev_d    = prev_q;
    lockout_d = lockout_q;
    scan_d    = scan_q;
    toggled   = 1'b0;
    clear_cnt = 1'b0;
    inc_cnt   = 1'b0;
    case (ssd_pkg::cmd_e'(in_i.cmd))
      ssd_pkg::CMD_TICK: begin
        if (lockout_q != '0) begin
          lockout_d = lockout_q - 1'b1;
        end
        if (run_q) begin
          inc_cnt   = 1'b1;
          elapsed_d = (elapsed_q == ssd_pkg::COUNT_LAST) ? '0 : elapsed_q + 1'b1;
        end
      end
      ssd_pkg::CMD_BUTTON: begin
        // Samples are dropped altogether while the lockout runs.
        if (lockout_q == '0) begin
          if (!in_i.level && prev_q) begin
            if (!run_q) begin
              clear_cnt = 1'b1;
              elapsed_d = '0;
            end
            run_d     = !run_q;
            lockout_d = lockout_ticks_q;
            toggled   = 1'b1;
          end
          prev_d = in_i.level;
        end
      end
      ssd_pkg::CMD_SCAN: begin
        scan_d = (scan_q == ScanLast) ? '0 : scan_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      run_q     <= 1'b0;
      prev_q    <= 1'b0;
      lockout_q <= '0;
      scan_q    <= '0;
    end else if (accept) begin
      elapsed_q <= elapsed_d;
      run_q     <= run_d;
      prev_q    <= prev_d;
      lockout_q <= lockout_d;
      scan_q    <= scan_d;
    end
  end

  // Decimal cells: the ones cell counts ticks, each higher one takes the
  // carry of the cell below.
  for (genvar i = 0; i < ssd_pkg::NUM_CELLS; i++) begin : g_cell
    assign cell_ctrl[i].clear = clear_cnt;
    if (i == 0) begin : g_first
      assign cell_ctrl[i].inc = inc_cnt;
    end else begin : g_next
      assign cell_ctrl[i].inc = carry[i-1];
    end
    ssd_digit_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (accept),
      .ctrl_i    (cell_ctrl[i]),
      .carry_o   (carry[i]),
      .digit_d_o (digit_d[i])
    );
  end

  // Positions above the thousands always show zero.
  always_comb begin
    pos   = ssd_pkg::POS_W'(scan_d);
    shown = '0;
    if (pos < ssd_pkg::POS_W'(ssd_pkg::NUM_CELLS)) begin
      shown = digit_d[pos[ssd_pkg::SEL_W-1:0]];
    end
    seg = ssd_pkg::seg_code(shown);
    if (pos == ssd_pkg::DP_DIGIT) begin
      seg[ssd_pkg::SEG_W-1] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_o.count        <= elapsed_d;
      out_o.running      <= run_d;
      out_o.toggled      <= toggled;
      out_o.digit_select <= pos[ssd_pkg::SEL_W-1:0];
      out_o.segments     <= seg;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

### sv/ssd_digit_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_digit_cell
// One decimal digit of the elapsed count; passes its carry to the next cell.
// ----------------------------------------------------------------------------
module ssd_digit_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  ssd_pkg::cell_ctrl_t         ctrl_i,
  output logic                        carry_o,
  output logic [ssd_pkg::BCD_W-1:0]   digit_d_o
);

  logic [ssd_pkg::BCD_W-1:0] digit_q, digit_d;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.inc) begin
      digit_d = (digit_q == ssd_pkg::BCD_LAST) ? '0 : digit_q + 1'b1;
    end
  end

  assign carry_o   = ctrl_i.inc && !ctrl_i.clear && (digit_q == ssd_pkg::BCD_LAST);
  assign digit_d_o = en_i ? digit_d : digit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else if (en_i) begin
      digit_q <= digit_d;
    end
  end

endmodule

### sv/ssd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_checker
// Port-level checks on the result channel of the stopwatch.
// ----------------------------------------------------------------------------
module ssd_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [ssd_pkg::COUNT_W-1:0]   count_i,
  input  logic                          running_i,
  input  logic                          toggled_i,
  input  logic [ssd_pkg::SEL_W-1:0]     digit_select_i,
  input  logic [ssd_pkg::SEG_W-1:0]     segments_i
);

  // A result word that is not taken stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> count_i <= ssd_pkg::COUNT_LAST)
    else $error("count beyond wrap point");

  // Starting the stopwatch always clears the count.
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && toggled_i && running_i |-> count_i == '0)
    else $error("count not cleared on start");

  // The decimal point is lit on digit two and nowhere else.
  a_dp_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (!segments_i[ssd_pkg::SEG_W-1]) == (digit_select_i == 2'd2))
    else $error("decimal point on wrong digit");

endmodule

bind start_stop_stopwatch_display_top ssd_checker u_ssd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .count_i        (out_o.count),
  .running_i      (out_o.running),
  .toggled_i      (out_o.toggled),
  .digit_select_i (out_o.digit_select),
  .segments_i     (out_o.segments)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the start/stop stopwatch. Every word that is
// accepted is run through a cycle-free model of the stopwatch. The readout
// that the model predicts is queued and then compared field by field with
// the result word that comes out. Directed tests cover the reset state and
// the three lockout settings. Random traffic follows, under changing idle
// and stall rates, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned     NUM_POS          = 4;
  localparam logic [2:0]      DP_POS           = 3'd2;
  localparam logic [9:0]      LOCKOUT_AT_RESET = 10'd100;
  localparam logic [9:0]      LOCKOUT_MAX      = 10'd1023;
  localparam logic [13:0]     WRAP_AT          = 14'd10000;
  localparam int unsigned     RESULT_LATENCY   = 2;
  localparam int unsigned     DRAIN_LIMIT      = 20000;
  localparam int unsigned     HOLD_CYCLES      = 300;
  localparam int unsigned     PHASE_WORDS      = 60;
  localparam longint unsigned TIMEOUT_NS       = 64'd5_000_000;

  typedef struct packed {
    logic [13:0] count;
    logic        running;
    logic        toggled;
    logic [1:0]  digit_select;
    logic [7:0]  segments;
  } readout_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [ssd_pkg::LOCKOUT_W-1:0] cfg_data_i;

  ssd_in_if  in_ch ();
  ssd_out_if out_ch ();

  start_stop_stopwatch_display_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // Model state of the stopwatch.
  logic [13:0] sw_elapsed;
  logic        sw_running;
  logic        sw_prev_level;
  logic [9:0]  sw_lock_left;
  logic [9:0]  sw_lockout;
  logic [1:0]  sw_scan;

  readout_t    pending_readouts[$];
  readout_t    oldest;

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned words_sent     = 0;
  int unsigned words_checked  = 0;
  int unsigned toggles_seen   = 0;
  int unsigned lockout_writes = 0;
  int unsigned errors         = 0;

  logic        hold_req  = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] digit_segments(input int unsigned d);
    logic [7:0] seg;
    case (d)
      0: seg = 8'hc0;
      1: seg = 8'hf9;
      2: seg = 8'ha4;
      3: seg = 8'hb0;
      4: seg = 8'h99;
      5: seg = 8'h92;
      6: seg = 8'h82;
      7: seg = 8'hf8;
      8: seg = 8'h80;
      default: seg = 8'h90;
    endcase
    return seg;
  endfunction

  // Applies one word to the model and returns the readout it leads to.
  function automatic readout_t step_stopwatch(input ssd_pkg::cmd_e cmd, input logic level);
    readout_t    w;
    int unsigned place;
    logic        toggle;
    toggle = 1'b0;
    case (cmd)
      ssd_pkg::CMD_TICK: begin
        if (sw_lock_left != '0) sw_lock_left = sw_lock_left - 1'b1;
        if (sw_running) begin
          sw_elapsed = (sw_elapsed == WRAP_AT - 1'b1) ? '0 : sw_elapsed + 1'b1;
        end
      end
      ssd_pkg::CMD_BUTTON: begin
        // Samples taken during the lockout are dropped, edge memory included.
        if (sw_lock_left == '0) begin
          if (!level && sw_prev_level) begin
            if (!sw_running) sw_elapsed = '0;
            sw_running   = ~sw_running;
            sw_lock_left = sw_lockout;
            toggle       = 1'b1;
          end
          sw_prev_level = level;
        end
      end
      ssd_pkg::CMD_SCAN: begin
        sw_scan = (sw_scan == NUM_POS - 1) ? '0 : sw_scan + 1'b1;
      end
      default: ;
    endcase
    case (sw_scan)
      2'd0: place = 1;
      2'd1: place = 10;
      2'd2: place = 100;
      default: place = 1000;
    endcase
    w.count        = sw_elapsed;
    w.running      = sw_running;
    w.toggled      = toggle;
    w.digit_select = sw_scan;
    w.segments     = digit_segments((int'(sw_elapsed) / place) % 10);
    if ({1'b0, sw_scan} == DP_POS) w.segments[7] = 1'b0;
    return w;
  endfunction

  // Offers one word, waits for the handshake and records the prediction.
  // valid is only lowered inside an idle gap, never at the acceptance edge.
  task automatic send_word(input ssd_pkg::cmd_e cmd, input logic level);
    readout_t w;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.level <= level;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    w = step_stopwatch(cmd, level);
    pending_readouts.push_back(w);
    words_sent++;
    if (w.toggled) toggles_seen++;
  endtask

  task automatic press_button(input int unsigned ticks_held);
    send_word(ssd_pkg::CMD_BUTTON, 1'b1);
    repeat (ticks_held) send_word(ssd_pkg::CMD_TICK, 1'($urandom_range(1)));
    send_word(ssd_pkg::CMD_BUTTON, 1'b0);
  endtask

  task automatic send_random_word();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      send_word(ssd_pkg::CMD_TICK, 1'($urandom_range(1)));
    end else if (pick < 55) begin
      send_word(ssd_pkg::CMD_SCAN, 1'($urandom_range(1)));
    end else if (pick < 85) begin
      press_button($urandom_range(3));
    end else if (pick < 95) begin
      send_word(ssd_pkg::CMD_BUTTON, 1'($urandom_range(1)));
    end else begin
      send_word(ssd_pkg::cmd_e'($urandom_range(3)), 1'($urandom_range(1)));
    end
  endtask

  // Stops offering words and waits until every predicted readout is back.
  task automatic wait_idle();
    int unsigned n;
    n = 0;
    in_ch.valid <= 1'b0;
    while (pending_readouts.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    if (pending_readouts.size() != 0) begin
      $error("%0d result words never arrived", pending_readouts.size());
      errors++;
    end
    repeat (RESULT_LATENCY) @(posedge clk_i);
  endtask

  task automatic write_lockout(input logic [9:0] ticks);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= ticks;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sw_lockout = ticks;
    lockout_writes++;
  endtask

  task automatic test_reset_values();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_word(ssd_pkg::CMD_NONE, 1'b1);
    send_word(ssd_pkg::CMD_TICK, 1'b0);
    repeat (NUM_POS) send_word(ssd_pkg::CMD_SCAN, 1'b0);
    send_word(ssd_pkg::CMD_BUTTON, 1'b0);
    send_word(ssd_pkg::CMD_NONE, 1'b0);
  endtask

  // Start under the reset lockout, try a press inside it, then stop once it
  // has run out; the stopped count must be kept and ticks no longer count.
  task automatic test_default_lockout();
    press_button(0);
    repeat (3) send_word(ssd_pkg::CMD_TICK, 1'b0);
    press_button(0);
    repeat (NUM_POS) send_word(ssd_pkg::CMD_SCAN, 1'b1);
    repeat (LOCKOUT_AT_RESET) send_word(ssd_pkg::CMD_TICK, 1'b1);
    press_button(0);
    repeat (2) send_word(ssd_pkg::CMD_TICK, 1'b0);
  endtask

  task automatic test_zero_lockout();
    write_lockout('0);
    press_button(0);
    repeat (5) send_word(ssd_pkg::CMD_TICK, 1'b0);
    press_button(0);
    send_word(ssd_pkg::CMD_BUTTON, 1'b0);
    send_word(ssd_pkg::CMD_BUTTON, 1'b1);
    send_word(ssd_pkg::CMD_BUTTON, 1'b1);
    send_word(ssd_pkg::CMD_BUTTON, 1'b0);
  endtask

  // With the longest lockout, a press one tick before it ends is ignored and
  // the press right after the last tick toggles.
  task automatic test_long_lockout();
    write_lockout(LOCKOUT_MAX);
    press_button(0);
    repeat (LOCKOUT_MAX - 1'b1) send_word(ssd_pkg::CMD_TICK, 1'b0);
    press_button(0);
    send_word(ssd_pkg::CMD_TICK, 1'b0);
    press_button(0);
  endtask

  task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned first;
    int unsigned sub;
    int unsigned pick;
    for (sub = 0; sub < 2; sub++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        write_lockout('0);
      end else if (pick < 90) begin
        write_lockout(10'($urandom_range(12, 1)));
      end else begin
        write_lockout(10'($urandom_range(60, 13)));
      end
      src_idle_pct   = idle_pct;
      sink_stall_pct = stall_pct;
      first = words_sent;
      while (words_sent - first < PHASE_WORDS) send_random_word();
    end
  endtask

  // The receiver holds off while words keep coming, so the block backs up.
  task automatic test_backpressure();
    write_lockout(10'd3);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req = ~hold_req;
    repeat (60) send_random_word();
    wait_idle();
  endtask

  // Receiver side: random stalls, or a long hold-off once requested.
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      words_checked++;
      if (pending_readouts.size() == 0) begin
        $error("result word arrived with nothing expected");
        errors++;
      end else begin
        oldest = pending_readouts.pop_front();
        if (out_ch.count !== oldest.count) begin
          $error("count: expected %0d, actual %0d", oldest.count, out_ch.count);
          errors++;
        end
        if (out_ch.running !== oldest.running) begin
          $error("running: expected %0d, actual %0d", oldest.running, out_ch.running);
          errors++;
        end
        if (out_ch.toggled !== oldest.toggled) begin
          $error("toggled: expected %0d, actual %0d", oldest.toggled, out_ch.toggled);
          errors++;
        end
        if (out_ch.digit_select !== oldest.digit_select) begin
          $error("digit_select: expected %0d, actual %0d",
                 oldest.digit_select, out_ch.digit_select);
          errors++;
        end
        if (out_ch.segments !== oldest.segments) begin
          $error("segments: expected 0x%02h, actual 0x%02h",
                 oldest.segments, out_ch.segments);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = '0;
    in_ch.valid   = 1'b0;
    in_ch.cmd     = ssd_pkg::CMD_NONE;
    in_ch.level   = 1'b0;
    out_ch.ready  = 1'b0;
    sw_elapsed    = '0;
    sw_running    = 1'b0;
    sw_prev_level = 1'b0;
    sw_lock_left  = '0;
    sw_lockout    = LOCKOUT_AT_RESET;
    sw_scan       = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_default_lockout();
    test_zero_lockout();
    test_long_lockout();
    run_random_phase(0, 0);
    run_random_phase(63, 0);
    run_random_phase(0, 63);
    run_random_phase(20, 20);
    test_backpressure();
    wait_idle();

    $display("Run covered %0d words and %0d checked results with %0d start/stop toggles,",
             words_sent, words_checked, toggles_seen);
    $display("%0d lockout settings, idle and stall mixes and a long receiver hold-off.",
             lockout_writes);
    if (errors == 0) begin
      $display("** start_stop_stopwatch_display_top: PASSED **");
    end else begin
      $display("** start_stop_stopwatch_display_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Run stopped: no progress within the time limit.");
    $display("** start_stop_stopwatch_display_top: FAILED **");
    $finish;
  end

endmodule
